// File: hw/rtl/xbc_pkg.sv
// Shared types, constants and helpers for the XPBD bending constraint solver.
// No dependencies.
package xbc_pkg;

    localparam int VTX_MAX = 4;
    localparam int VTX_IW  = 2;
    localparam int CNT_W   = 3;

    localparam logic signed [63:0] SAT_MAX = 64'sh0000_0000_7FFF_FFFF;
    localparam logic signed [63:0] SAT_MIN = 64'shFFFF_FFFF_8000_0000;

    localparam logic [30:0] STIFF_RESET = 31'd65536;
    localparam logic [30:0] DT_RESET    = 31'd1092;
    localparam logic [30:0] EPS_RESET   = 31'd1;

    typedef enum logic [2:0] {
        REG_COEFF_0   = 3'd0,
        REG_COEFF_1   = 3'd1,
        REG_COEFF_2   = 3'd2,
        REG_COEFF_3   = 3'd3,
        REG_REST      = 3'd4,
        REG_STIFFNESS = 3'd5,
        REG_TIME_STEP = 3'd6,
        REG_EPSILON   = 3'd7
    } reg_idx_t;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] beta_x;
        logic signed [31:0] beta_y;
        logic signed [31:0] beta_z;
        logic [30:0]        mass_recip;
        logic               use_beta;
        logic               restart_lambda;
        logic               last_vertex;
    } vertex_t;

    typedef struct packed {
        logic signed [31:0] new_x;
        logic signed [31:0] new_y;
        logic signed [31:0] new_z;
        logic               corrected;
        logic               last_result;
    } result_t;

    typedef struct packed {
        logic [VTX_MAX-1:0][31:0] coeff;
        logic [30:0]              rest_curvature_sq;
        logic [30:0]              stiffness;
        logic [30:0]              time_step;
        logic [30:0]              epsilon;
    } cfg_t;

    typedef struct packed {
        vertex_t          v;
        logic             store;
        logic [CNT_W-1:0] idx;
        logic [CNT_W-1:0] n;
    } entry_t;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        if (v > SAT_MAX)
            return SAT_MAX[31:0];
        if (v < SAT_MIN)
            return SAT_MIN[31:0];
        return v[31:0];
    endfunction

endpackage

// File: hw/rtl/xbc_if.sv
// Valid/ready channel interfaces for vertex items and result items.
// Depends on xbc_pkg.
interface xbc_vertex_if;
    import xbc_pkg::*;
    logic    valid;
    logic    ready;
    vertex_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface xbc_result_if;
    import xbc_pkg::*;
    logic    valid;
    logic    ready;
    result_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// File: hw/rtl/xpbd_bending_constraint_solve.sv
// Top level of the XPBD bending constraint solver: APB registers, front, queue, back.
// Depends on xbc_pkg, xbc_if, xbc_front, xbc_queue, xbc_back.
//
//   port      dir   handshake        content
//   vertex    in    valid/ready      one vertex of a constraint
//   result    out   valid/ready      one corrected vertex, n per solve
//   apb       in    psel/penable     coefficient and solver registers
//
// A vertex item is taken whenever the two-entry queue has room.
// After the last vertex is taken, the solve runs on one shared 32x32 multiplier,
// each product formed in S_MUL and accumulated in S_ACC. When the correction
// applies, two divisions follow (the first skipped when alpha saturates); when
// it does not, there are none. The results then go out one per handshake.
// Reset clears control state and loads the register defaults; a stalled
// result holds the back end while the front keeps filling the queue.
module xpbd_bending_constraint_solve #(
    parameter int VERTEX_COUNT = 4,
    parameter int FRAC_BITS    = 16
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    xbc_vertex_if.sink   vertex,
    xbc_result_if.source result
);
    import xbc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t widx;
    logic     wr;
    logic     push;
    logic     pop;
    logic     full;
    logic     empty;
    entry_t   push_entry;
    entry_t   head;

    assign pready = 1'b1;
    assign wr     = psel && penable && pwrite;
    assign widx   = reg_idx_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.coeff             <= '0;
            cfg_reg.rest_curvature_sq <= '0;
            cfg_reg.stiffness         <= STIFF_RESET;
            cfg_reg.time_step         <= DT_RESET;
            cfg_reg.epsilon           <= EPS_RESET;
        end
        else if (wr)
        begin
            unique case (widx) inside
                REG_COEFF_0, REG_COEFF_1, REG_COEFF_2, REG_COEFF_3:
                    cfg_reg.coeff[paddr[3:2]] <= pwdata;
                REG_REST:
                    cfg_reg.rest_curvature_sq <= pwdata[30:0];
                REG_STIFFNESS:
                    cfg_reg.stiffness <= pwdata[30:0];
                REG_TIME_STEP:
                    cfg_reg.time_step <= pwdata[30:0];
                REG_EPSILON:
                    cfg_reg.epsilon <= pwdata[30:0];
                default:
                    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (widx) inside
            REG_COEFF_0, REG_COEFF_1, REG_COEFF_2, REG_COEFF_3:
                prdata = cfg_reg.coeff[paddr[3:2]];
            REG_REST:
                prdata = {1'b0, cfg_reg.rest_curvature_sq};
            REG_STIFFNESS:
                prdata = {1'b0, cfg_reg.stiffness};
            REG_TIME_STEP:
                prdata = {1'b0, cfg_reg.time_step};
            REG_EPSILON:
                prdata = {1'b0, cfg_reg.epsilon};
            default:
                prdata = '0;
        endcase
    end

    xbc_front #(.VERTEX_COUNT(VERTEX_COUNT)) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .vertex     (vertex),
        .full       (full),
        .push       (push),
        .push_entry (push_entry)
    );

    xbc_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (full),
        .empty      (empty)
    );

    xbc_back #(
        .VERTEX_COUNT (VERTEX_COUNT),
        .FRAC_BITS    (FRAC_BITS)
    ) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg_reg),
        .empty  (empty),
        .head   (head),
        .pop    (pop),
        .result (result)
    );

endmodule

// File: hw/rtl/xbc_front.sv
// Front end: accepts vertex items, tracks the load count, classifies each item.
// Depends on xbc_pkg and xbc_if.
module xbc_front #(
    parameter int VERTEX_COUNT = 4
) (
    input  logic            clk,
    input  logic            rst_n,
    xbc_vertex_if.sink      vertex,
    input  logic            full,
    output logic            push,
    output xbc_pkg::entry_t push_entry
);
    import xbc_pkg::*;

    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;
    logic             take;
    logic             store;

    assign vertex.ready = !full;
    assign take         = vertex.valid && !full;
    assign store        = cnt_reg < CNT_W'(VERTEX_COUNT);
    assign push         = take && (store || vertex.data.last_vertex);

    always_comb
    begin
        push_entry.v     = vertex.data;
        push_entry.store = store;
        push_entry.idx   = cnt_reg;
        push_entry.n     = store ? cnt_reg + CNT_W'(1) : cnt_reg;
        cnt_next         = cnt_reg;
        if (take)
        begin
            if (vertex.data.last_vertex)
                cnt_next = '0;
            else if (store)
                cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

endmodule

// File: hw/rtl/xbc_queue.sv
// Two-entry queue of classified items between front and back end.
// Depends on xbc_pkg.
module xbc_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  xbc_pkg::entry_t push_entry,
    input  logic            pop,
    output xbc_pkg::entry_t head,
    output logic            full,
    output logic            empty
);
    import xbc_pkg::*;

    entry_t     mem_reg [2];
    logic       wptr_reg;
    logic       rptr_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;

    assign full  = cnt_reg == 2'd2;
    assign empty = cnt_reg == 2'd0;
    assign head  = mem_reg[rptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 2'd1;
        else if (pop && !push)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            if (push)
                wptr_reg <= !wptr_reg;
            if (pop)
                rptr_reg <= !rptr_reg;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wptr_reg] <= push_entry;
    end

endmodule

// File: hw/rtl/xbc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// No dependencies.
module xbc_div #(
    parameter int W = 48
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [30:0]  divisor,
    output logic         done,
    output logic [W-1:0] quotient
);
    localparam int CW = $clog2(W + 1);

    logic          busy_reg;
    logic          done_reg;
    logic [CW-1:0] cnt_reg;
    logic [30:0]   rem_reg;
    logic [W-1:0]  quo_reg;
    logic [30:0]   dvs_reg;
    logic [31:0]   rem_sh;
    logic [31:0]   rem_sub;
    logic          ge;

    assign rem_sh   = {rem_reg, quo_reg[W-1]};
    assign ge       = rem_sh >= {1'b0, dvs_reg};
    assign rem_sub  = rem_sh - {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CW'(W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CW'(1);
                if (cnt_reg == CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rem_sub[30:0] : rem_sh[30:0];
            quo_reg <= {quo_reg[W-2:0], ge};
        end
    end

endmodule

// File: hw/rtl/xbc_back.sv
// Back end: vertex store, solve sequencer on one shared multiplier, result output.
// Depends on xbc_pkg, xbc_if and xbc_div.
module xbc_back #(
    parameter int VERTEX_COUNT = 4,
    parameter int FRAC_BITS    = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  xbc_pkg::cfg_t   cfg,
    input  logic            empty,
    input  xbc_pkg::entry_t head,
    output logic            pop,
    xbc_result_if.source    result
);
    import xbc_pkg::*;

    localparam int IW = (VERTEX_COUNT > 1) ? $clog2(VERTEX_COUNT) : 1;
    localparam int DW = 32 + FRAC_BITS;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ACC  = 6'b000100,
        S_DIVA = 6'b001000,
        S_DIVS = 6'b010000,
        S_OUT  = 6'b100000
    } state_t;

    typedef enum logic [3:0] {
        OP_K, OP_C, OP_G, OP_GG, OP_GB, OP_W, OP_KDT, OP_KDT2, OP_NUM, OP_SM, OP_P
    } op_t;

    state_t             state_reg;
    state_t             state_next;
    op_t                op_reg;
    logic [IW-1:0]      i_reg;
    logic [1:0]         d_reg;
    logic [CNT_W-1:0]   n_reg;
    logic               use_beta_reg;
    logic               restart_reg;
    logic               applied_reg;
    logic               neg_reg;
    logic signed [31:0] mult_reg;

    logic signed [31:0] pos_reg  [VERTEX_COUNT][3];
    logic signed [31:0] beta_reg [VERTEX_COUNT][3];
    logic signed [31:0] grad_reg [VERTEX_COUNT][3];
    logic [30:0]        mass_reg [VERTEX_COUNT];
    logic signed [31:0] cur_reg  [3];
    logic signed [63:0] p_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] nsq_reg;
    logic signed [63:0] w_reg;
    logic signed [63:0] b_reg;
    logic signed [31:0] c_reg;
    logic signed [31:0] kdt_reg;
    logic signed [31:0] alpha_reg;
    logic signed [31:0] s_reg;
    logic signed [31:0] sm_reg;

    logic signed [31:0] a_sel;
    logic signed [31:0] b_sel;
    logic signed [63:0] q;
    logic signed [63:0] acc_sum;
    logic signed [63:0] rest64;
    logic signed [63:0] eps64;
    logic signed [63:0] quo64;
    logic signed [31:0] w_fin;
    logic signed [31:0] kdt2_c;
    logic signed [31:0] num_c;
    logic signed [31:0] den_c;
    logic signed [31:0] s_c;
    logic [31:0]        num_abs;
    logic               last_i;
    logic               last_d;
    logic               take_last;
    logic               div_start;
    logic [DW-1:0]      div_dividend;
    logic [30:0]        div_divisor;
    logic               div_done;
    logic [DW-1:0]      div_quot;

    xbc_div #(.W(DW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quot)
    );

    assign pop       = (state_reg == S_IDLE) && !empty;
    assign take_last = pop && head.v.last_vertex;
    assign last_i    = CNT_W'(i_reg) == n_reg - CNT_W'(1);
    assign last_d    = d_reg == 2'd2;
    assign q         = p_reg >>> FRAC_BITS;
    assign acc_sum   = acc_reg + q;
    assign rest64    = signed'(64'(cfg.rest_curvature_sq));
    assign eps64     = signed'(64'(cfg.epsilon));
    assign quo64     = signed'(64'(div_quot));
    assign w_fin     = sat32(w_reg + q);
    assign kdt2_c    = sat32(q);
    assign num_c     = sat32(64'(c_reg) + q - b_reg);
    assign den_c     = sat32(w_reg + 64'(alpha_reg));
    assign num_abs   = num_c[31] ? 32'(-num_c) : 32'(num_c);
    assign s_c       = sat32(neg_reg ? -quo64 : quo64);

    always_comb
    begin
        a_sel = '0;
        b_sel = '0;
        case (op_reg)
            OP_K:
            begin
                a_sel = signed'(cfg.coeff[VTX_IW'(i_reg)]);
                b_sel = pos_reg[i_reg][d_reg];
            end
            OP_C:
            begin
                a_sel = cur_reg[d_reg];
                b_sel = cur_reg[d_reg];
            end
            OP_G:
            begin
                a_sel = cur_reg[d_reg];
                b_sel = signed'(cfg.coeff[VTX_IW'(i_reg)]);
            end
            OP_GG:
            begin
                a_sel = grad_reg[i_reg][d_reg];
                b_sel = grad_reg[i_reg][d_reg];
            end
            OP_GB:
            begin
                a_sel = grad_reg[i_reg][d_reg];
                b_sel = beta_reg[i_reg][d_reg];
            end
            OP_W:
            begin
                a_sel = signed'({1'b0, mass_reg[i_reg]});
                b_sel = sat32(nsq_reg);
            end
            OP_KDT:
            begin
                a_sel = signed'({1'b0, cfg.stiffness});
                b_sel = signed'({1'b0, cfg.time_step});
            end
            OP_KDT2:
            begin
                a_sel = kdt_reg;
                b_sel = signed'({1'b0, cfg.time_step});
            end
            OP_NUM:
            begin
                a_sel = alpha_reg;
                b_sel = mult_reg;
            end
            OP_SM:
            begin
                a_sel = s_reg;
                b_sel = signed'({1'b0, mass_reg[i_reg]});
            end
            OP_P:
            begin
                a_sel = sm_reg;
                b_sel = grad_reg[i_reg][d_reg];
            end
            default:
            begin
                a_sel = '0;
                b_sel = '0;
            end
        endcase
    end

    always_comb
    begin
        div_start    = 1'b0;
        div_dividend = DW'(1) << (2 * FRAC_BITS);
        div_divisor  = kdt2_c[30:0];
        if (state_reg == S_ACC && op_reg == OP_KDT2 && kdt2_c > 32'sd0)
            div_start = 1'b1;
        if (state_reg == S_ACC && op_reg == OP_NUM)
        begin
            div_start    = 1'b1;
            div_dividend = {num_abs, {FRAC_BITS{1'b0}}};
            div_divisor  = den_c[30:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (take_last)
                    state_next = S_MUL;
            S_MUL:
                state_next = S_ACC;
            S_ACC:
            begin
                state_next = S_MUL;
                case (op_reg)
                    OP_W:
                        if (last_i && !(64'(w_fin) > eps64))
                            state_next = S_OUT;
                    OP_KDT2:
                        if (kdt2_c > 32'sd0)
                            state_next = S_DIVA;
                    OP_NUM:
                        state_next = S_DIVS;
                    OP_P:
                        if (last_d && last_i)
                            state_next = S_OUT;
                    default:
                        state_next = S_MUL;
                endcase
            end
            S_DIVA:
                if (div_done)
                    state_next = S_MUL;
            S_DIVS:
                if (div_done)
                    state_next = S_MUL;
            S_OUT:
                if (result.ready && last_i)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            op_reg       <= OP_K;
            i_reg        <= '0;
            d_reg        <= '0;
            n_reg        <= '0;
            use_beta_reg <= 1'b0;
            restart_reg  <= 1'b0;
            applied_reg  <= 1'b0;
            neg_reg      <= 1'b0;
            mult_reg     <= '0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                S_IDLE:
                    if (take_last)
                    begin
                        op_reg       <= OP_K;
                        i_reg        <= '0;
                        d_reg        <= '0;
                        n_reg        <= head.n;
                        use_beta_reg <= head.v.use_beta;
                        restart_reg  <= head.v.restart_lambda;
                        applied_reg  <= 1'b0;
                    end
                S_MUL:
                    ;
                S_ACC:
                    case (op_reg)
                        OP_K:
                            if (last_i)
                            begin
                                i_reg <= '0;
                                if (last_d)
                                begin
                                    d_reg  <= '0;
                                    op_reg <= OP_C;
                                end
                                else
                                    d_reg <= d_reg + 2'd1;
                            end
                            else
                                i_reg <= i_reg + IW'(1);
                        OP_C:
                            if (last_d)
                            begin
                                d_reg  <= '0;
                                i_reg  <= '0;
                                op_reg <= OP_G;
                            end
                            else
                                d_reg <= d_reg + 2'd1;
                        OP_G:
                            op_reg <= OP_GG;
                        OP_GG, OP_GB:
                            if (op_reg == OP_GG && use_beta_reg)
                                op_reg <= OP_GB;
                            else if (last_d)
                                op_reg <= OP_W;
                            else
                            begin
                                d_reg  <= d_reg + 2'd1;
                                op_reg <= OP_G;
                            end
                        OP_W:
                        begin
                            d_reg <= '0;
                            if (last_i)
                            begin
                                i_reg <= '0;
                                if (restart_reg)
                                    mult_reg <= '0;
                                op_reg <= OP_KDT;
                            end
                            else
                            begin
                                i_reg  <= i_reg + IW'(1);
                                op_reg <= OP_G;
                            end
                        end
                        OP_KDT:
                            op_reg <= OP_KDT2;
                        OP_KDT2:
                            op_reg <= OP_NUM;
                        OP_NUM:
                        begin
                            neg_reg <= num_c[31];
                            op_reg  <= OP_SM;
                        end
                        OP_SM:
                            op_reg <= OP_P;
                        OP_P:
                            if (last_d)
                            begin
                                d_reg <= '0;
                                if (last_i)
                                begin
                                    i_reg       <= '0;
                                    applied_reg <= 1'b1;
                                end
                                else
                                begin
                                    i_reg  <= i_reg + IW'(1);
                                    op_reg <= OP_SM;
                                end
                            end
                            else
                                d_reg <= d_reg + 2'd1;
                        default:
                            op_reg <= op_reg;
                    endcase
                S_DIVA:
                    ;
                S_DIVS:
                    if (div_done)
                    begin
                        mult_reg <= sat32(64'(mult_reg) - 64'(s_c));
                        i_reg    <= '0;
                        d_reg    <= '0;
                    end
                S_OUT:
                    if (result.ready)
                        i_reg <= last_i ? '0 : i_reg + IW'(1);
                default:
                    ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head.store)
        begin
            pos_reg[head.idx[IW-1:0]][0]  <= head.v.pos_x;
            pos_reg[head.idx[IW-1:0]][1]  <= head.v.pos_y;
            pos_reg[head.idx[IW-1:0]][2]  <= head.v.pos_z;
            beta_reg[head.idx[IW-1:0]][0] <= head.v.beta_x;
            beta_reg[head.idx[IW-1:0]][1] <= head.v.beta_y;
            beta_reg[head.idx[IW-1:0]][2] <= head.v.beta_z;
            mass_reg[head.idx[IW-1:0]]    <= head.v.mass_recip;
        end
        if (take_last)
        begin
            acc_reg <= '0;
            nsq_reg <= '0;
            w_reg   <= '0;
            b_reg   <= '0;
        end
        if (state_reg == S_MUL)
            p_reg <= a_sel * b_sel;
        if (state_reg == S_ACC)
        begin
            case (op_reg)
                OP_K:
                    if (last_i)
                    begin
                        cur_reg[d_reg] <= sat32(acc_sum);
                        acc_reg        <= '0;
                    end
                    else
                        acc_reg <= acc_sum;
                OP_C:
                    if (last_d)
                    begin
                        c_reg   <= sat32(64'(sat32(acc_sum)) - rest64);
                        acc_reg <= '0;
                    end
                    else
                        acc_reg <= acc_sum;
                OP_G:
                    grad_reg[i_reg][d_reg] <= sat32(q <<< 1);
                OP_GG:
                    nsq_reg <= nsq_reg + q;
                OP_GB:
                    b_reg <= b_reg + q;
                OP_W:
                begin
                    nsq_reg <= '0;
                    if (last_i)
                    begin
                        w_reg <= 64'(w_fin);
                        b_reg <= 64'(sat32(b_reg));
                    end
                    else
                        w_reg <= w_reg + q;
                end
                OP_KDT:
                    kdt_reg <= sat32(q);
                OP_KDT2:
                    if (!(kdt2_c > 32'sd0))
                        alpha_reg <= SAT_MAX[31:0];
                OP_SM:
                    sm_reg <= sat32(q);
                OP_P:
                    pos_reg[i_reg][d_reg] <= sat32(64'(pos_reg[i_reg][d_reg]) - q);
                default:
                    ;
            endcase
        end
        if (state_reg == S_DIVA && div_done)
            alpha_reg <= sat32(quo64);
        if (state_reg == S_DIVS && div_done)
            s_reg <= s_c;
    end

    assign result.valid            = state_reg == S_OUT;
    assign result.data.new_x       = pos_reg[i_reg][0];
    assign result.data.new_y       = pos_reg[i_reg][1];
    assign result.data.new_z       = pos_reg[i_reg][2];
    assign result.data.corrected   = applied_reg;
    assign result.data.last_result = last_i;

endmodule

// File: bench/tb_xbc_defs.sv
// Testbench types and shared constants for the bending constraint solver bench.
// Depends on xbc_pkg.
`timescale 1ns / 1ps
package tb_xbc_defs;
    import xbc_pkg::*;

    localparam int FRAC   = 16;
    localparam int NVTX   = 4;
    localparam int S32MAX = 32'sh7FFF_FFFF;

    typedef struct {
        vertex_t v;
        logic    check_known;
        result_t known;
    } stim_row_t;
endpackage

// File: bench/tb.sv
// Top-level bench for xpbd_bending_constraint_solve: directed table, then random constraints.
// Every result is checked against a fixed-point bending solver model kept in this file.
// Depends on xbc_pkg, xbc_if, tb_xbc_defs and the RTL.
`timescale 1ns / 1ps
module tb;
    import xbc_pkg::*;
    import tb_xbc_defs::*;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [4:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;

    xbc_vertex_if vtx_ch ();
    xbc_result_if res_ch ();

    xpbd_bending_constraint_solve dut (
        .clk(clk), .rst_n(rst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
        .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .vertex(vtx_ch.sink), .result(res_ch.source)
    );

    always #4 clk = ~clk;

    // model state
    longint pos_mem [12];
    longint beta_mem [12];
    longint mass_mem [4];
    longint lambda_q;
    int     loaded;
    longint coeff_q [4];
    longint rest_q, stiff_q, dt_q, eps_q;

    result_t corrected_q [$];
    int     errors = 0;
    longint cycles = 0;
    bit     long_hold = 1'b0;

    function automatic longint clip(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic longint qmul(longint a, longint b);
        longint p;
        p = a * b;
        return p >>> FRAC;
    endfunction

    task automatic solve_bend(int n, bit with_beta, bit restart);
        longint kv [3];
        longint g [4][3];
        longint acc, c, w, b, nsq, alpha, kdt, kdt2, num, den, s, sm;
        bit applied;
        result_t r;
        w = 0;
        b = 0;
        applied = 1'b0;
        for (int d = 0; d < 3; d++)
        begin
            acc = 0;
            for (int i = 0; i < n; i++)
                acc += qmul(coeff_q[i], pos_mem[i*3+d]);
            kv[d] = clip(acc);
        end
        c = 0;
        for (int d = 0; d < 3; d++)
            c += qmul(kv[d], kv[d]);
        c = clip(clip(c) - rest_q);
        for (int i = 0; i < n; i++)
        begin
            nsq = 0;
            for (int d = 0; d < 3; d++)
            begin
                g[i][d] = clip(2 * qmul(kv[d], coeff_q[i]));
                nsq += qmul(g[i][d], g[i][d]);
                if (with_beta)
                    b += qmul(g[i][d], beta_mem[i*3+d]);
            end
            w += qmul(mass_mem[i], clip(nsq));
        end
        w = clip(w);
        b = clip(b);
        if (restart)
            lambda_q = 0;
        if (w > eps_q)
        begin
            kdt = clip(qmul(stiff_q, dt_q));
            kdt2 = clip(qmul(kdt, dt_q));
            if (kdt2 <= 0)
                alpha = S32MAX;
            else
                alpha = clip((64'sd1 <<< (2*FRAC)) / kdt2);
            num = clip(c + qmul(alpha, lambda_q) - b);
            den = clip(w + alpha);
            s = clip((num * (64'sd1 <<< FRAC)) / den);
            lambda_q = clip(lambda_q - s);
            applied = 1'b1;
            for (int i = 0; i < n; i++)
            begin
                sm = clip(qmul(s, mass_mem[i]));
                for (int d = 0; d < 3; d++)
                    pos_mem[i*3+d] = clip(pos_mem[i*3+d] - qmul(sm, g[i][d]));
            end
        end
        for (int i = 0; i < n; i++)
        begin
            r.new_x = pos_mem[i*3][31:0];
            r.new_y = pos_mem[i*3+1][31:0];
            r.new_z = pos_mem[i*3+2][31:0];
            r.corrected = applied;
            r.last_result = (i + 1 == n);
            corrected_q.push_back(r);
        end
    endtask

    task automatic take_vertex(vertex_t v);
        int n;
        if (loaded < NVTX)
        begin
            pos_mem[loaded*3] = longint'(v.pos_x);
            pos_mem[loaded*3+1] = longint'(v.pos_y);
            pos_mem[loaded*3+2] = longint'(v.pos_z);
            beta_mem[loaded*3] = longint'(v.beta_x);
            beta_mem[loaded*3+1] = longint'(v.beta_y);
            beta_mem[loaded*3+2] = longint'(v.beta_z);
            mass_mem[loaded] = longint'({1'b0, v.mass_recip});
            loaded++;
        end
        if (v.last_vertex)
        begin
            n = loaded;
            loaded = 0;
            solve_bend(n, v.use_beta, v.restart_lambda);
        end
    endtask

    task automatic write_reg(reg_idx_t idx, logic [31:0] val);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx) inside
            REG_COEFF_0, REG_COEFF_1, REG_COEFF_2, REG_COEFF_3:
                coeff_q[idx] = longint'($signed(val));
            REG_REST: rest_q = longint'({1'b0, val[30:0]});
            REG_STIFFNESS: stiff_q = longint'({1'b0, val[30:0]});
            REG_TIME_STEP: dt_q = longint'({1'b0, val[30:0]});
            REG_EPSILON: eps_q = longint'({1'b0, val[30:0]});
            default: ;
        endcase
    endtask

    task automatic send_vertex(vertex_t v);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap != 0)
        begin
            vtx_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        vtx_ch.valid <= 1'b1;
        vtx_ch.data <= v;
        @(posedge clk);
        while (!vtx_ch.ready)
            @(posedge clk);
        take_vertex(v);
    endtask

    task automatic drain_and_settle();
        vtx_ch.valid <= 1'b0;
        while (corrected_q.size() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom();
            default: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
        endcase
    endfunction

    function automatic vertex_t rand_vertex(bit last);
        vertex_t v;
        v.pos_x = rand_q();
        v.pos_y = rand_q();
        v.pos_z = rand_q();
        v.beta_x = rand_q();
        v.beta_y = rand_q();
        v.beta_z = rand_q();
        v.mass_recip = ($urandom_range(0, 4) == 0) ? 31'($urandom()) :
                       31'($urandom_range(0, 32'h0002_0000));
        v.use_beta = 1'($urandom_range(0, 1));
        v.restart_lambda = 1'($urandom_range(0, 1));
        v.last_vertex = last;
        return v;
    endfunction

    function automatic vertex_t mk(logic [31:0] p, logic [31:0] bta, logic [30:0] m,
                                   bit ub, bit rl, bit lst);
        vertex_t v;
        v.pos_x = p;
        v.pos_y = ~p;
        v.pos_z = p ^ 32'h5555_5555;
        v.beta_x = bta;
        v.beta_y = ~bta;
        v.beta_z = bta ^ 32'h3333_3333;
        v.mass_recip = m;
        v.use_beta = ub;
        v.restart_lambda = rl;
        v.last_vertex = lst;
        return v;
    endfunction

    // result side
    always @(posedge clk)
    begin
        result_t exp_r;
        result_t got;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            got = res_ch.data;
            if (corrected_q.size() == 0)
            begin
                $display("%0t unexpected result: expected none, actual %h", $time, got);
                errors++;
            end
            else
            begin
                exp_r = corrected_q.pop_front();
                if (got.new_x !== exp_r.new_x)
                begin
                    $display("%0t new_x: expected %h, actual %h", $time, exp_r.new_x, got.new_x);
                    errors++;
                end
                if (got.new_y !== exp_r.new_y)
                begin
                    $display("%0t new_y: expected %h, actual %h", $time, exp_r.new_y, got.new_y);
                    errors++;
                end
                if (got.new_z !== exp_r.new_z)
                begin
                    $display("%0t new_z: expected %h, actual %h", $time, exp_r.new_z, got.new_z);
                    errors++;
                end
                if (got.corrected !== exp_r.corrected)
                begin
                    $display("%0t corrected: expected %b, actual %b", $time,
                             exp_r.corrected, got.corrected);
                    errors++;
                end
                if (got.last_result !== exp_r.last_result)
                begin
                    $display("%0t last_result: expected %b, actual %b", $time,
                             exp_r.last_result, got.last_result);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (long_hold)
            begin
                res_ch.ready <= 1'b0;
                repeat (600) @(posedge clk);
                long_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (gap != 0)
            begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
            while (!res_ch.valid)
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 64'd2000000)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        stim_row_t rows [$];
        stim_row_t row;
        int nv;
        vtx_ch.valid = 1'b0;
        vtx_ch.data = '0;
        for (int i = 0; i < 12; i++)
        begin
            pos_mem[i] = 0;
            beta_mem[i] = 0;
        end
        for (int i = 0; i < 4; i++)
        begin
            mass_mem[i] = 0;
            coeff_q[i] = 0;
        end
        lambda_q = 0;
        loaded = 0;
        rest_q = 0;
        stiff_q = 65536;
        dt_q = 1092;
        eps_q = 1;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // after reset coefficients are zero: single vertex passes through uncorrected
        row.v = mk(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 1'b1, 1'b1, 1'b1);
        row.check_known = 1'b1;
        row.known = '{new_x: 32'h7FFF_FFFF, new_y: 32'h8000_0000, new_z: 32'h2AAA_AAAA,
                      corrected: 1'b0, last_result: 1'b1};
        rows.push_back(row);
        row.check_known = 1'b0;
        row.v = mk(32'h8000_0000, 32'h7FFF_FFFF, 31'd0, 1'b0, 1'b0, 1'b1);
        rows.push_back(row);
        foreach (rows[i])
        begin
            send_vertex(rows[i].v);
            if (rows[i].check_known && corrected_q[$] !== rows[i].known)
            begin
                $display("%0t table row %0d: expected %h, actual %h", $time, i,
                         rows[i].known, corrected_q[$]);
                errors++;
            end
        end
        drain_and_settle();

        write_reg(REG_COEFF_0, 32'h0001_0000);
        write_reg(REG_COEFF_1, 32'hFFFE_0000);
        write_reg(REG_COEFF_2, 32'h0001_0000);
        write_reg(REG_COEFF_3, 32'h0000_8000);
        write_reg(REG_REST, 32'h0000_1000);
        write_reg(REG_STIFFNESS, 32'h0001_0000);
        write_reg(REG_TIME_STEP, 32'h0000_1000);
        write_reg(REG_EPSILON, 32'h0000_0001);
        // directed: full constraint, overlong constraint, short constraints, extremes
        rows.delete();
        for (int i = 0; i < 4; i++)
        begin
            row.v = mk(32'h0001_0000 << i, 32'h0000_4000, 31'h0001_0000, 1'b1, i == 0, i == 3);
            rows.push_back(row);
        end
        for (int i = 0; i < 6; i++)
        begin
            row.v = mk(32'h0000_8000 * i, 32'hFFFF_0000, 31'h0000_8000, 1'b0, 1'b0, i == 5);
            rows.push_back(row);
        end
        row.v = mk(32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 1'b0, 1'b1);
        rows.push_back(row);
        row.v = mk(32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF, 1'b0, 1'b0, 1'b0);
        rows.push_back(row);
        row.v = mk(32'hFFFF_FFFF, 32'h0000_0001, 31'h0000_0000, 1'b1, 1'b1, 1'b1);
        rows.push_back(row);
        foreach (rows[i])
            send_vertex(rows[i].v);
        // sender pause until all results are back
        drain_and_settle();

        // extremes: stiffness product truncates to zero, alpha huge/near zero, epsilon max
        write_reg(REG_STIFFNESS, 32'h0000_0001);
        write_reg(REG_TIME_STEP, 32'h0000_0001);
        for (int i = 0; i < 3; i++)
            send_vertex(rand_vertex(i == 2));
        drain_and_settle();
        write_reg(REG_STIFFNESS, 32'h7FFF_FFFF);
        write_reg(REG_TIME_STEP, 32'h7FFF_FFFF);
        write_reg(REG_REST, 32'h7FFF_FFFF);
        write_reg(REG_COEFF_2, 32'h8000_0000);
        write_reg(REG_COEFF_3, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_vertex(rand_vertex(i == 3));
        drain_and_settle();
        write_reg(REG_EPSILON, 32'h7FFF_FFFF);
        for (int i = 0; i < 4; i++)
            send_vertex(rand_vertex(i == 3));
        drain_and_settle();

        // random phases with different settings
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_COEFF_0, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
            write_reg(REG_COEFF_1, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
            write_reg(REG_COEFF_2, $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
            write_reg(REG_COEFF_3, (ph == 3) ? $urandom() : $urandom_range(0, 32'h0002_0000));
            write_reg(REG_REST, $urandom_range(0, 32'h0004_0000));
            write_reg(REG_STIFFNESS, $urandom_range(1, 32'h0010_0000));
            write_reg(REG_TIME_STEP, $urandom_range(1, 32'h0000_4000));
            write_reg(REG_EPSILON, (ph == 0) ? 0 : $urandom_range(0, 32'h100));
            if (ph == 1)
                long_hold = 1'b1;
            for (int c = 0; c < 5; c++)
            begin
                nv = ($urandom_range(0, 5) == 0) ? $urandom_range(1, 6) : 4;
                for (int i = 0; i < nv; i++)
                    send_vertex(rand_vertex(i == nv - 1));
            end
            drain_and_settle();
        end

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
